// ===== sv/ordered_array_list_engine_core_assert.svh =====
// Assertion macros shared by the list engine.
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTH
`define OAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OAL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/oal_pkg.sv =====
`default_nettype none

package oal_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int LEN_W   = 8;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_LOCATE = 3'd3,
        OP_PRIOR  = 3'd4,
        OP_NEXT   = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
    } t_query;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               just;
        logic               got;
        logic [POS_W-1:0]   idx;
        logic [VALUE_W-1:0] prev;
        logic [VALUE_W-1:0] rval;
    } t_carry;

    typedef struct packed {
        logic               ins;
        logic               del;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
    } t_apply;

endpackage

`default_nettype wire

// ===== sv/oal_req_if.sv =====
`default_nettype none

interface oal_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [6:0]         position;
    logic signed [31:0] item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input item_value,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/oal_rsp_if.sv =====
`default_nettype none

interface oal_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [6:0]         result_index;
    logic [7:0]         entry_total;
    logic               is_empty;

    modport source (output valid, output status, output result_value, output result_index,
                    output entry_total, output is_empty, input ready);
    modport sink   (input valid, input status, input result_value, input result_index,
                    input entry_total, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== sv/oal_cell.sv =====
`default_nettype none

module oal_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire oal_pkg::t_query              i_query,
    input  wire logic [CW-1:0]                i_count,
    input  wire oal_pkg::t_carry              i_carry,
    output oal_pkg::t_carry                   o_carry,
    input  wire oal_pkg::t_apply              i_apply,
    input  wire logic [oal_pkg::VALUE_W-1:0]  i_left,
    input  wire logic [oal_pkg::VALUE_W-1:0]  i_right,
    output logic [oal_pkg::VALUE_W-1:0]       o_value
);
    import oal_pkg::*;

    localparam int KW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] r_value;
    t_carry             r_carry;
    t_carry             n_carry;
    logic [KW-1:0]      w_k;
    logic [KW-1:0]      w_qpos;
    logic [KW-1:0]      w_apos;
    logic               w_active;
    logic               w_match;

    assign w_k      = KW'(IDX);
    assign w_qpos   = KW'(i_query.pos);
    assign w_apos   = KW'(i_apply.pos);
    assign w_active = w_k < KW'(i_count);
    assign w_match  = r_value == i_query.val;

    always_comb begin
        n_carry      = i_carry;
        n_carry.just = 1'b0;
        if (w_active) begin
            case (i_query.op)
                OP_GET, OP_DELETE: begin
                    if (w_k == w_qpos) begin
                        n_carry.rval = r_value;
                        n_carry.got  = 1'b1;
                    end
                end
                OP_LOCATE: begin
                    if (!i_carry.hit && w_match) begin
                        n_carry.hit = 1'b1;
                        n_carry.idx = POS_W'(IDX);
                    end
                end
                OP_PRIOR: begin
                    if (!i_carry.hit && w_match) begin
                        n_carry.hit = 1'b1;
                        if (IDX != 0) begin
                            n_carry.rval = i_carry.prev;
                            n_carry.got  = 1'b1;
                        end
                    end
                end
                OP_NEXT: begin
                    if (i_carry.just && !i_carry.got) begin
                        n_carry.rval = r_value;
                        n_carry.got  = 1'b1;
                    end
                    if (!i_carry.hit && w_match) begin
                        n_carry.hit  = 1'b1;
                        n_carry.just = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            n_carry.prev = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.valid <= 1'b0;
        end else begin
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_apply.ins) begin
            if (w_k > w_apos) begin
                r_value <= i_left;
            end else if (w_k == w_apos) begin
                r_value <= i_apply.val;
            end
        end else if (i_apply.del) begin
            if (w_k >= w_apos) begin
                r_value <= i_right;
            end
        end
    end

    assign o_carry = r_carry;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== sv/ordered_array_list_engine_core.sv =====
// Ordered array list engine: a list of signed 32-bit values kept in a row
// of cells, one entry per cell.
// Requests arrive on i_req (operation, position, item_value); every accepted
// transaction gives exactly one response transaction on o_rsp with status,
// result_value, result_index, entry_total and is_empty.
// Insert, clear and rejected requests go straight to the finish state and
// then to the output register. Get, delete, locate, prior and next send a
// query token down the cell row, one cell per cycle, and finish once it
// leaves the last cell; that walk through the row sets the throughput.
// One request is in service at a time: i_req.ready is high only while the
// engine is idle. A finished response is held in an output register until
// the receiver takes it; while it waits, a new request is still accepted and
// its own result waits in the engine until the output register is free.
// Shifts for insert and delete happen at once: the cells above the position
// take a neighbour's value (on delete, the cell at the position does too).
// Reset empties the list and drops any pending response; entry contents are
// not cleared, since only entries below the length are ever read.
`default_nettype none

module ordered_array_list_engine_core #(
    parameter int CAPACITY = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    oal_req_if.sink    i_req,
    oal_rsp_if.source  o_rsp
);
    import oal_pkg::*;

    `include "ordered_array_list_engine_core_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [CW-1:0]      r_count, n_count;
    logic               r_launch, n_launch;
    logic [1:0]         r_status, n_status;
    logic [VALUE_W-1:0] r_rval, n_rval;
    logic [POS_W-1:0]   r_ridx, n_ridx;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_o_status, n_o_status;
    logic [VALUE_W-1:0] r_o_rval, n_o_rval;
    logic [POS_W-1:0]   r_o_ridx, n_o_ridx;
    logic [CW-1:0]      r_o_len, n_o_len;
    logic               w_del;

    logic               w_accept;
    logic               w_fire;
    t_query             w_query;
    t_apply             w_apply;
    t_carry             w_carry_start;
    t_carry             w_carry [CAPACITY+1];
    logic [VALUE_W-1:0] w_value [CAPACITY];

    assign i_req.ready = r_state == S_IDLE;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_fire      = (r_state == S_FINISH) && (!r_out_valid || o_rsp.ready);
    assign w_del       = (r_op == OP_DELETE) && (r_status == ST_OK);

    assign w_query = '{op: r_op, pos: r_pos, val: r_val};

    assign w_apply.ins = w_fire && (r_op == OP_INSERT) && (r_status == ST_OK);
    assign w_apply.del = w_fire && w_del;
    assign w_apply.pos = r_pos;
    assign w_apply.val = r_val;

    assign w_carry_start = '{valid: r_launch, hit: 1'b0, just: 1'b0, got: 1'b0,
                             idx: '0, prev: '0, rval: '0};
    assign w_carry[0] = w_carry_start;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end
        oal_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_query (w_query),
            .i_count (r_count),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .i_apply (w_apply),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_count     = r_count;
        n_launch    = 1'b0;
        n_status    = r_status;
        n_rval      = r_rval;
        n_ridx      = r_ridx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_rval    = r_o_rval;
        n_o_ridx    = r_o_ridx;
        n_o_len     = r_o_len;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_req.operation;
                    n_pos    = i_req.position;
                    n_val    = i_req.item_value;
                    n_rval   = '0;
                    n_ridx   = '0;
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                    case (i_req.operation)
                        OP_GET, OP_DELETE: begin
                            if (KW'(i_req.position) < KW'(r_count)) begin
                                n_state  = S_SCAN;
                                n_launch = 1'b1;
                            end else begin
                                n_status = ST_BAD;
                            end
                        end
                        OP_INSERT: begin
                            if (!(KW'(i_req.position) <= KW'(r_count)
                                  && r_count < CW'(CAPACITY))) begin
                                n_status = ST_BAD;
                            end
                        end
                        OP_LOCATE, OP_PRIOR, OP_NEXT: begin
                            n_state  = S_SCAN;
                            n_launch = 1'b1;
                        end
                        OP_CLEAR: begin
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_carry[CAPACITY].valid) begin
                    n_state = S_FINISH;
                    case (r_op)
                        OP_LOCATE: begin
                            n_status = w_carry[CAPACITY].hit ? ST_OK : ST_MISS;
                            n_ridx   = w_carry[CAPACITY].hit ? w_carry[CAPACITY].idx : '0;
                        end
                        default: begin
                            n_status = w_carry[CAPACITY].got ? ST_OK : ST_MISS;
                            n_rval   = w_carry[CAPACITY].got ? w_carry[CAPACITY].rval : '0;
                        end
                    endcase
                end
            end
            S_FINISH: begin
                if (w_fire) begin
                    if (w_apply.ins) begin
                        n_count = r_count + 1'b1;
                    end else if (w_apply.del) begin
                        n_count = r_count - 1'b1;
                    end else if (r_op == OP_CLEAR) begin
                        n_count = '0;
                    end
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_rval    = r_rval;
                    n_o_ridx    = r_ridx;
                    n_o_len     = n_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_status   <= n_status;
        r_rval     <= n_rval;
        r_ridx     <= n_ridx;
        r_o_status <= n_o_status;
        r_o_rval   <= n_o_rval;
        r_o_ridx   <= n_o_ridx;
        r_o_len    <= n_o_len;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.result_value = r_o_rval;
    assign o_rsp.result_index = r_o_ridx;
    assign o_rsp.entry_total  = LEN_W'(r_o_len);
    assign o_rsp.is_empty     = r_o_len == '0;

    `OAL_ASSERT_NEXT(a_one_in_service, i_clk, i_rst_n, w_accept, !i_req.ready)
    `OAL_ASSERT_SAME(a_token_only_in_scan, i_clk, i_rst_n, w_carry[CAPACITY].valid,
                     r_state == S_SCAN)
    `OAL_ASSERT_SAME(a_delete_needs_entry, i_clk, i_rst_n, (r_state == S_FINISH) && w_del,
                     r_count != '0)
    `OAL_ASSERT_SAME(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))

endmodule

`default_nettype wire
